>>> hw/rtl/bdcd_pkg.sv
// ----------------------------------------------------------------------------
// bdcd_pkg: shared types and constants
// Payload structs, action codes and register indexes for the debounce and
// command decoder.
// ----------------------------------------------------------------------------
package bdcd_pkg;

    localparam int NUM_BUTTONS = 8;
    localparam int SEL_W       = 4;

    // Selection code meaning "nothing selected"
    localparam logic [SEL_W-1:0] NO_SEL = 4'hF;

    // Fixed button combinations
    localparam logic [NUM_BUTTONS-1:0] COMBO_SELECT4 = 8'h05;
    localparam logic [NUM_BUTTONS-1:0] COMBO_TEMP    = 8'h03;
    localparam logic [NUM_BUTTONS-1:0] COMBO_LRS_ON  = 8'h06;
    localparam logic [NUM_BUTTONS-1:0] COMBO_LRS_OFF = 8'h0A;
    localparam logic [NUM_BUTTONS-1:0] COMBO_TYPE    = 8'h18;
    localparam logic [NUM_BUTTONS-1:0] COMBO_DIET    = 8'h30;
    localparam logic [NUM_BUTTONS-1:0] COMBO_REGULAR = 8'hC0;
    localparam logic [NUM_BUTTONS-1:0] COMBO_BEEP    = 8'hA0;
    localparam logic [NUM_BUTTONS-1:0] SLOT4_BIT     = 8'h10;
    localparam logic [SEL_W-1:0]       SLOT4_SEL     = 4'd4;

    // Configuration register indexes
    localparam logic [7:0] REG_DEBOUNCE_THRESHOLD = 8'd0;
    localparam logic [7:0] REG_RANDOM_BUTTON      = 8'd1;

    localparam logic [7:0] DEBOUNCE_RESET = 8'd10;
    localparam logic [2:0] RANDOM_RESET   = 3'd7;

    typedef enum logic [3:0] {
        ACT_NONE      = 4'd0,
        ACT_SELECT    = 4'd1,
        ACT_TEMP      = 4'd2,
        ACT_TYPE      = 4'd3,
        ACT_RAND_ANY  = 4'd4,
        ACT_RAND_DIET = 4'd5,
        ACT_RAND_REG  = 4'd6,
        ACT_BEEP      = 4'd7,
        ACT_LRS_ON    = 4'd8,
        ACT_LRS_OFF   = 4'd9
    } action_t;

    typedef enum logic [1:0] {
        LAMP_NONE   = 2'd0,
        LAMP_SWEEP  = 2'd1,
        LAMP_WHEEL  = 2'd2
    } lamp_mode_t;

    typedef struct packed {
        logic [7:0] buttons_pressed;
        logic [7:0] sold_out_mask;
    } in_item_t;

    typedef struct packed {
        action_t    action;
        logic       beep;
        logic       select_valid;
        logic [2:0] select_index;
        logic [7:0] relay_drive;
        lamp_mode_t lamp_mode;
        logic [2:0] lamp_index;
        logic [7:0] lamp_level;
        logic       larsen_enabled;
    } out_item_t;

    // Decoder result handed to the relay and lamp stage
    typedef struct packed {
        action_t          action;
        logic [SEL_W-1:0] sel;
        logic             lamps;
        logic             sweep_set;
        logic             sweep_clr;
    } decode_t;

endpackage

>>> hw/rtl/button_debounce_command_decoder.sv
// ----------------------------------------------------------------------------
// button_debounce_command_decoder: panel debounce and command decoder
// Debounces the button mask per scan tick, decodes it into an action and
// drives relays plus the Larsen sweep / color wheel lamp state.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                              Moves
//  -------  ---------------------------------  ----------------------------
//  input    s_valid s_ready s_data             one scan tick (buttons, sold)
//  result   m_valid m_ready m_data             one result per tick
//  config   cfg_valid cfg_ready cfg_index/data register write
//
//  One transaction per clock while m_ready is high: a tick sits in the input
//  register, then combinational decode logic produces the result register and
//  updates all state.
//  aresetn (synchronous, active low) clears control and state; config
//  registers return to threshold 10 and random button 7.
//  A stalled result holds the result register; the input register then
//  fills and s_ready drops. cfg_ready is always high.
// ----------------------------------------------------------------------------
module button_debounce_command_decoder
    import bdcd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,

    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,

    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_index,
    input  logic [7:0] cfg_data
);

    // Configuration
    logic [7:0] threshold_reg;
    logic [2:0] random_btn_reg;

    // Pipeline registers
    logic      in_valid_reg;
    in_item_t  in_data_reg;
    logic      out_valid_reg;
    out_item_t out_data_reg;
    out_item_t out_data_next;

    // Block state
    logic [7:0]       prev_mask_reg, prev_mask_next;
    logic [7:0]       stable_cnt_reg, stable_cnt_next;
    logic             sweep_en_reg, sweep_en_next;
    logic [SEL_W-1:0] last_sel_reg, last_sel_next;
    logic [7:0]       wheel_reg, wheel_next;
    logic [10:0]      sweep_pos_reg, sweep_pos_next;

    logic             advance;
    logic [7:0]       accepted_mask;
    decode_t          dec;
    logic             sel_changed;
    logic [7:0]       wheel_eff;
    logic [10:0]      sweep_eff;
    logic [7:0]       relay;

    // Tick moves from input register to result register when the result
    // slot is free or being drained this cycle.
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;
    assign cfg_ready = 1'b1;

    // Debounce: mask counts only after more than threshold stable ticks
    always_comb begin
        prev_mask_next  = prev_mask_reg;
        stable_cnt_next = stable_cnt_reg;
        accepted_mask   = in_data_reg.buttons_pressed;
        if (prev_mask_reg != in_data_reg.buttons_pressed) begin
            prev_mask_next  = in_data_reg.buttons_pressed;
            stable_cnt_next = '0;
            accepted_mask   = '0;
        end else if (stable_cnt_reg <= threshold_reg) begin
            if (stable_cnt_reg != 8'hFF) begin
                stable_cnt_next = stable_cnt_reg + 8'd1;
            end
            accepted_mask = '0;
        end
    end

    bdcd_decode u_decode (
        .mask          (accepted_mask),
        .sold          (in_data_reg.sold_out_mask),
        .random_button (random_btn_reg),
        .dec           (dec)
    );

    // Relay and lamp stage
    always_comb begin
        sweep_en_next = sweep_en_reg;
        if (dec.sweep_set) begin
            sweep_en_next = 1'b1;
        end else if (dec.sweep_clr) begin
            sweep_en_next = 1'b0;
        end

        sel_changed = dec.lamps && (last_sel_reg != dec.sel);
        wheel_eff   = sel_changed ? 8'd0 : wheel_reg;
        sweep_eff   = sel_changed ? 11'd0 : sweep_pos_reg;

        last_sel_next  = dec.lamps ? dec.sel : last_sel_reg;
        wheel_next     = wheel_eff;
        sweep_pos_next = sweep_eff;

        out_data_next                = '0;
        out_data_next.action         = dec.action;
        out_data_next.beep           = (dec.action == ACT_BEEP);
        out_data_next.select_valid   = (dec.sel != NO_SEL);
        out_data_next.select_index   = (dec.sel != NO_SEL) ? dec.sel[2:0] : 3'd0;
        out_data_next.lamp_mode      = LAMP_NONE;
        out_data_next.larsen_enabled = sweep_en_next;

        if (dec.lamps) begin
            if ((dec.sel == NO_SEL) && sweep_en_next) begin
                out_data_next.lamp_mode  = LAMP_SWEEP;
                out_data_next.lamp_index = sweep_eff[10:8];
                out_data_next.lamp_level = sweep_eff[7:0];
                sweep_pos_next           = sweep_eff + 11'd1;   // wraps at 2048
            end else begin
                out_data_next.lamp_mode  = LAMP_WHEEL;
                out_data_next.lamp_index = (dec.sel == NO_SEL) ? 3'd0 : dec.sel[2:0];
                out_data_next.lamp_level = wheel_eff;
                wheel_next               = wheel_eff + 8'd1;
            end
        end

        // Relays follow the held selection, active low
        relay = '1;
        if (!last_sel_next[SEL_W-1]) begin
            relay[last_sel_next[2:0]] = 1'b0;
        end
        out_data_next.relay_drive = relay;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg  <= DEBOUNCE_RESET;
            random_btn_reg <= RANDOM_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == REG_DEBOUNCE_THRESHOLD) begin
                threshold_reg <= cfg_data;
            end else if (cfg_index == REG_RANDOM_BUTTON) begin
                random_btn_reg <= cfg_data[2:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            prev_mask_reg  <= '0;
            stable_cnt_reg <= '0;
            sweep_en_reg   <= 1'b0;
            last_sel_reg   <= NO_SEL;
            wheel_reg      <= '0;
            sweep_pos_reg  <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                out_valid_reg  <= 1'b1;
                prev_mask_reg  <= prev_mask_next;
                stable_cnt_reg <= stable_cnt_next;
                sweep_en_reg   <= sweep_en_next;
                last_sel_reg   <= last_sel_next;
                wheel_reg      <= wheel_next;
                sweep_pos_reg  <= sweep_pos_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_relay_one_low: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> ($countones(~out_data_reg.relay_drive) <= 1))
        else $error("more than one relay driven");

    a_select_wheel: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_data_reg.select_valid) |->
        (out_data_reg.lamp_mode == LAMP_WHEEL))
        else $error("selection without color wheel update");

    a_larsen_on: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_data_reg.action == ACT_LRS_ON)) |->
        out_data_reg.larsen_enabled)
        else $error("larsen on action left sweep disabled");

    a_beep_match: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_data_reg.beep == (out_data_reg.action == ACT_BEEP)))
        else $error("beep flag disagrees with action");

    a_stall_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> ($stable(sweep_pos_reg) && $stable(wheel_reg)))
        else $error("lamp state moved while result stalled");

endmodule

>>> hw/rtl/bdcd_decode.sv
// ----------------------------------------------------------------------------
// bdcd_decode: command decoder
// Turns a debounced button mask into one action and an optional slot.
// ----------------------------------------------------------------------------
module bdcd_decode
    import bdcd_pkg::*;
(
    input  logic [NUM_BUTTONS-1:0] mask,
    input  logic [7:0]             sold,
    input  logic [2:0]             random_button,
    output decode_t                dec
);

    logic [NUM_BUTTONS-1:0] rand_mask;
    logic                   single;
    logic [2:0]             bit_idx;

    assign rand_mask = NUM_BUTTONS'(1) << random_button;
    assign single    = (mask != '0) && ((mask & (mask - 1'b1)) == '0);

    always_comb begin
        unique case (mask)
            8'h01:   bit_idx = 3'd0;
            8'h02:   bit_idx = 3'd1;
            8'h04:   bit_idx = 3'd2;
            8'h08:   bit_idx = 3'd3;
            8'h10:   bit_idx = 3'd4;
            8'h20:   bit_idx = 3'd5;
            8'h40:   bit_idx = 3'd6;
            8'h80:   bit_idx = 3'd7;
            default: bit_idx = 3'd0;
        endcase
    end

    always_comb begin
        dec           = '0;
        dec.action    = ACT_NONE;
        dec.sel       = NO_SEL;
        dec.lamps     = 1'b1;
        if (mask == '0) begin
            dec.action = ACT_NONE;
        end else if (mask == COMBO_SELECT4) begin
            if ((sold & SLOT4_BIT) != '0) begin
                dec.action = ACT_BEEP;
            end else begin
                dec.action = ACT_SELECT;
                dec.sel    = SLOT4_SEL;
            end
        end else if (mask == COMBO_TEMP) begin
            dec.action = ACT_TEMP;
            dec.lamps  = 1'b0;
        end else if (mask == COMBO_LRS_ON) begin
            dec.action    = ACT_LRS_ON;
            dec.sweep_set = 1'b1;
        end else if (mask == COMBO_LRS_OFF) begin
            dec.action    = ACT_LRS_OFF;
            dec.sweep_clr = 1'b1;
        end else if (mask == COMBO_TYPE) begin
            dec.action = ACT_TYPE;
            dec.lamps  = 1'b0;
        end else if (mask == rand_mask) begin
            dec.action = ACT_RAND_ANY;
        end else if (mask == COMBO_DIET) begin
            dec.action = ACT_RAND_DIET;
        end else if (mask == COMBO_REGULAR) begin
            dec.action = ACT_RAND_REG;
        end else if (mask == COMBO_BEEP) begin
            dec.action = ACT_BEEP;
        end else if (single) begin
            if ((mask & sold) != '0) begin
                dec.action = ACT_BEEP;
            end else begin
                dec.action = ACT_SELECT;
                dec.sel    = {1'b0, bit_idx};
            end
        end
    end

endmodule
